/* hdl/dsg_pkg.sv */
// Types and constants shared by the DDS step generator modules.
package dsg_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_FREQ_SCALE  = 2'd0;
  localparam logic [1:0] CFG_STEP_BIT    = 2'd1;
  localparam logic [1:0] CFG_JOINT_INDEX = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Reset values of the configuration registers
  localparam logic [31:0] FREQ_SCALE_RST  = 32'd6871948;
  localparam logic [4:0]  STEP_BIT_RST    = 5'd22;
  localparam logic [2:0]  JOINT_INDEX_RST = 3'd0;

  // Width of the scaled magnitude: 64-bit product shifted right by 16
  localparam int unsigned PROD_W = 48;

  typedef struct packed {
    logic signed [31:0] freq_cmd;
    logic [7:0]         joint_enables;
  } in_item_t;

  typedef struct packed {
    logic               enable_n;
    logic               step_out;
    logic               dir_out;
    logic signed [31:0] feedback;
    logic signed [31:0] position;
  } out_item_t;

  // Scaled command handed from the multiplier stage to the accumulator
  typedef struct packed {
    logic [PROD_W-1:0] mag;
    logic              neg;
    logic              enabled;
  } scale_item_t;

endpackage

/* hdl/dds_step_pulse_generator.sv */
// Top level of the DDS step pulse generator for one stepper joint.
// Each item is one servo tick. An item is taken every clock cycle while the
// result side keeps up; after acceptance it is registered first in the 32x32
// scaling multiplier register and then in the phase accumulator, whose pin
// levels, feedback and position form the result. The result register holds
// while stalled and one more item can wait in the multiplier stage behind it.
// Configuration is taken from the write port at any edge and is meant to
// change only while no item is in flight.
module dds_step_pulse_generator #(
  parameter int ACC_WIDTH   = 32,
  parameter int JOINT_COUNT = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  dsg_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output dsg_pkg::out_item_t                 out_item,
  input  logic                               cfg_wr_en,
  input  logic [dsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dsg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dsg_pkg::*;

  logic [31:0] freq_scale_r;
  logic [4:0]  step_bit_r;
  logic [2:0]  joint_index_r;

  logic        s1_valid_r, s1_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_accept;
  logic        s2_load;
  scale_item_t scale_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_scale_r  <= FREQ_SCALE_RST;
      step_bit_r    <= STEP_BIT_RST;
      joint_index_r <= JOINT_INDEX_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FREQ_SCALE:  freq_scale_r  <= cfg_wdata;
        CFG_STEP_BIT:    step_bit_r    <= cfg_wdata[4:0];
        CFG_JOINT_INDEX: joint_index_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Advance into the accumulator unless the result register is held
  assign s2_load   = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !s2_load);
  assign out_valid_nxt = s2_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  dsg_scale #(
    .JOINT_COUNT(JOINT_COUNT)
  ) u_scale (
    .clk        (clk),
    .load       (in_accept),
    .in_item    (in_item),
    .freq_scale (freq_scale_r),
    .joint_index(joint_index_r),
    .scale_item (scale_item)
  );

  dsg_accum #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s2_load),
    .scale_item(scale_item),
    .step_bit  (step_bit_r),
    .out_item  (out_item)
  );

  assign out_valid = out_valid_r;

  a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && !scale_item.enabled) |=>
      (out_item.enable_n && $stable(out_item.step_out) && $stable(out_item.dir_out)
       && $stable(out_item.feedback)))
    else $error("disabled item changed step state");

  a_enabled_drives: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && scale_item.enabled) |=> !out_item.enable_n)
    else $error("enabled item left driver disabled");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && !cfg_wr_en) |=> (out_valid_r && $stable(out_item)))
    else $error("stalled result changed");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted item lost before scaling stage");

endmodule

/* hdl/dsg_scale.sv */
// Scaling stage: absolute command times Q16.16 scale, registered.
module dsg_scale #(
  parameter int JOINT_COUNT = 8
) (
  input  logic                 clk,
  input  logic                 load,
  input  dsg_pkg::in_item_t    in_item,
  input  logic [31:0]          freq_scale,
  input  logic [2:0]           joint_index,
  output dsg_pkg::scale_item_t scale_item
);
  import dsg_pkg::*;

  logic [31:0]  cmd_mag;
  logic         cmd_neg;
  logic [63:0]  prod;
  logic         enabled;
  scale_item_t  scale_r;
  scale_item_t  scale_nxt;

  assign cmd_neg = in_item.freq_cmd[31];
  assign cmd_mag = cmd_neg ? (~in_item.freq_cmd + 32'd1) : in_item.freq_cmd;
  assign prod    = {32'd0, cmd_mag} * {32'd0, freq_scale};

  // Joints past the configured count are never enabled
  assign enabled = (int'(joint_index) < JOINT_COUNT) && in_item.joint_enables[joint_index];

  always_comb begin
    scale_nxt.mag     = prod[63:16];
    scale_nxt.neg     = cmd_neg;
    scale_nxt.enabled = enabled;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      scale_r <= scale_nxt;
    end
  end

  assign scale_item = scale_r;

endmodule

/* hdl/dsg_accum.sv */
// Accumulator stage: saturate, add, detect step toggle, hold pin levels.
module dsg_accum #(
  parameter int ACC_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  dsg_pkg::scale_item_t scale_item,
  input  logic [4:0]           step_bit,
  output dsg_pkg::out_item_t   out_item
);
  import dsg_pkg::*;

  localparam int EXT_W = (ACC_WIDTH > 32) ? ACC_WIDTH : 32;
  // Half-step offset taken from the reset step bit
  localparam logic [ACC_WIDTH-1:0] PHASE_RST = ACC_WIDTH'(64'd1 << (STEP_BIT_RST - 5'd1));

  logic [ACC_WIDTH-1:0] phase_r, phase_nxt;
  logic [ACC_WIDTH-1:0] fb_r, fb_nxt;
  logic                 step_r, step_nxt;
  logic                 dir_r, dir_nxt;
  logic                 en_r, en_nxt;

  logic [31:0]          sat_mag;
  logic signed [31:0]   add32;
  logic [ACC_WIDTH-1:0] add_acc;
  logic [ACC_WIDTH-1:0] phase_sum;
  logic [ACC_WIDTH-1:0] flip;
  logic                 toggled;
  logic                 fwd;
  logic signed [EXT_W-1:0] pos_ext;
  logic signed [EXT_W-1:0] pos_shift;

  // Clamp magnitude; negative side reaches one further
  always_comb begin
    if (scale_item.neg) begin
      sat_mag = (scale_item.mag > PROD_W'(32'h8000_0000)) ? 32'h8000_0000 : scale_item.mag[31:0];
      add32   = signed'(~sat_mag + 32'd1);
      fwd     = 1'b0;
    end else begin
      sat_mag = (scale_item.mag > PROD_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : scale_item.mag[31:0];
      add32   = signed'(sat_mag);
      fwd     = (sat_mag != 32'd0);
    end
  end

  assign add_acc   = ACC_WIDTH'(add32);
  assign phase_sum = phase_r + add_acc;
  assign flip      = (phase_r ^ phase_sum) >> step_bit;
  assign toggled   = flip[0];

  always_comb begin
    phase_nxt = phase_r;
    fb_nxt    = fb_r;
    step_nxt  = step_r;
    dir_nxt   = dir_r;
    en_nxt    = en_r;
    if (load) begin
      if (scale_item.enabled) begin
        en_nxt    = 1'b0;
        phase_nxt = phase_sum;
        step_nxt  = toggled;
        if (toggled) begin
          dir_nxt = fwd;
          fb_nxt  = phase_sum;
        end
      end else begin
        // Disabled joint: hold everything but the enable pin
        en_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_RST;
      fb_r    <= '0;
      step_r  <= 1'b0;
      dir_r   <= 1'b0;
      en_r    <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      fb_r    <= fb_nxt;
      step_r  <= step_nxt;
      dir_r   <= dir_nxt;
      en_r    <= en_nxt;
    end
  end

  assign pos_ext   = EXT_W'(signed'(phase_r));
  assign pos_shift = pos_ext >>> step_bit;

  always_comb begin
    out_item.enable_n = en_r;
    out_item.step_out = step_r;
    out_item.dir_out  = dir_r;
    out_item.feedback = 32'(signed'(fb_r));
    out_item.position = pos_shift[31:0];
  end

endmodule
